// ===== design/escaped_text_segment_splitter_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the escaped text segment splitter
// Each macro expands to a labeled concurrent assertion on clk, disabled
// while arst_n is low; in a synthesis build the macros expand to nothing.
// ---------------------------------------------------------------------------
`ifndef ESCAPED_TEXT_SEGMENT_SPLITTER_UNIT_ASSERT_SVH
`define ESCAPED_TEXT_SEGMENT_SPLITTER_UNIT_ASSERT_SVH
`ifndef SYNTH
// expr must hold at every clock edge
`define ESSC_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);
// when cond holds, expr must hold in the same cycle
`define ESSC_ASSERT_IMPLIES(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);
`else
`define ESSC_ASSERT_ALWAYS(label, expr, msg)
`define ESSC_ASSERT_IMPLIES(label, cond, expr, msg)
`endif
`endif

// ===== design/essc_pkg.sv =====
// ---------------------------------------------------------------------------
// essc_pkg
// Types, codes and helpers shared by the segment splitter modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package essc_pkg;

	// results one input word can cause
	localparam int MaxRes     = 5;
	localparam int CntW       = $clog2(MaxRes + 1);
	localparam int QueueDepth = 4;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QCntW      = $clog2(QueueDepth + 1);

	// result channels
	localparam logic [1:0] CH_TEXT = 2'd0;
	localparam logic [1:0] CH_COMP = 2'd1;
	localparam logic [1:0] CH_ERR  = 2'd2;

	// error report codes
	localparam logic [7:0] ERR_TRUNCATED = 8'd0;
	localparam logic [7:0] ERR_UNKNOWN   = 8'd1;

	// sentinel value after reset
	localparam logic [7:0] SENTINEL_RESET = 8'h02;

	// newline segment 02 10 01 03
	localparam logic [7:0] NL_OPENER = 8'h02;
	localparam logic [7:0] NL_TYPE   = 8'h10;
	localparam logic [7:0] NL_CODE   = 8'h01;
	localparam logic [7:0] NL_TAIL   = 8'h03;
	localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;

	// length codes
	localparam logic [7:0] LEN_EXT_BASE = 8'hF0;
	localparam logic [7:0] LEN_EXT1A    = 8'hF0;
	localparam logic [7:0] LEN_EXT1B    = 8'hF1;
	localparam logic [7:0] LEN_EXT2     = 8'hF2;
	localparam logic [7:0] LEN_EXT3     = 8'hFA;
	localparam logic [7:0] LEN_EXT4     = 8'hFE;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       string_end;
	} in_word_t;

	typedef struct packed {
		logic [1:0] channel;
		logic [7:0] value;
		logic       component_end;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic [1:0] channel;
		logic [7:0] value;
		logic       component_end;
	} slot_t;

	// all results caused by one input word
	typedef struct packed {
		slot_t [MaxRes-1:0] slots;
		logic [CntW-1:0]    count;
	} cmd_t;

	function automatic slot_t mk_slot(input logic [1:0] ch, input logic [7:0] val,
			input logic fin);
		slot_t s;
		s.channel       = ch;
		s.value         = val;
		s.component_end = fin;
		return s;
	endfunction

	// append one result, drop it once the command is full
	function automatic cmd_t push(input cmd_t c, input slot_t s);
		cmd_t r;
		r = c;
		if (r.count < CntW'(MaxRes)) begin
			r.slots[r.count] = s;
			r.count = r.count + 1'b1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/essc_front.sv =====
// ---------------------------------------------------------------------------
// essc_front
// Segment parser: takes one byte a cycle while the queue is not full and
// turns it into a command that lists every result the byte causes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module essc_front import essc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_ready,
	input  wire in_word_t   byte_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data,
	input  wire logic       q_full,
	output logic            q_push,
	output cmd_t            q_cmd
);

	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_SENT      = 3'd1;
	localparam logic [2:0] PH_TYPE_HELD = 3'd2;
	localparam logic [2:0] PH_TYPE      = 3'd3;
	localparam logic [2:0] PH_LENB      = 3'd4;
	localparam logic [2:0] PH_PAY       = 3'd5;
	localparam logic [2:0] PH_NL        = 3'd6;
	localparam logic [2:0] PH_ERR       = 3'd7;

	logic [7:0]  sentinel_q;
	logic [2:0]  phase_q, phase_d;
	logic [7:0]  held_type_q, held_type_d;
	logic [7:0]  held_code_q, held_code_d;
	logic [31:0] acc_q, acc_d;
	logic [2:0]  lenb_left_q, lenb_left_d;
	logic [32:0] pay_left_q, pay_left_d;
	logic        err_q, err_d;
	logic        accept;
	logic [7:0]  b;
	logic [2:0]  lb;
	logic [32:0] pl;
	logic        held;
	cmd_t        cmd;

	assign byte_ready = !q_full;
	assign cfg_ready  = 1'b1;
	assign accept     = byte_valid && byte_ready;
	assign b          = byte_data.data_byte;
	assign held       = (phase_q == PH_TYPE_HELD);

	// parse one byte
	always_comb begin
		phase_d     = phase_q;
		held_type_d = held_type_q;
		held_code_d = held_code_q;
		acc_d       = acc_q;
		lenb_left_d = lenb_left_q;
		pay_left_d  = pay_left_q;
		err_d       = err_q;
		lb          = lenb_left_q;
		pl          = pay_left_q;
		cmd         = '0;
		case (phase_q)
			PH_IDLE: begin
				if (b == sentinel_q) begin
					phase_d = PH_SENT;
				end else begin
					cmd = push(cmd, mk_slot(CH_TEXT, b, 1'b0));
				end
			end
			PH_SENT: begin
				held_type_d = b;
				if (sentinel_q == NL_OPENER && b == NL_TYPE) begin
					phase_d = PH_TYPE_HELD;
				end else begin
					cmd = push(cmd, mk_slot(CH_TEXT, sentinel_q, 1'b0));
					cmd = push(cmd, mk_slot(CH_COMP, sentinel_q, 1'b0));
					cmd = push(cmd, mk_slot(CH_COMP, b, 1'b0));
					phase_d = PH_TYPE;
				end
			end
			PH_TYPE_HELD, PH_TYPE: begin
				held_code_d = b;
				if (held && b == NL_CODE) begin
					phase_d = PH_NL;
				end else if (b >= LEN_EXT_BASE && !(b inside {LEN_EXT1A, LEN_EXT1B,
						LEN_EXT2, LEN_EXT3, LEN_EXT4})) begin
					cmd = push(cmd, mk_slot(CH_ERR, ERR_UNKNOWN, 1'b0));
					phase_d = PH_ERR;
					err_d   = 1'b1;
				end else begin
					if (held) begin
						cmd = push(cmd, mk_slot(CH_TEXT, sentinel_q, 1'b0));
						cmd = push(cmd, mk_slot(CH_COMP, sentinel_q, 1'b0));
						cmd = push(cmd, mk_slot(CH_COMP, held_type_q, 1'b0));
					end
					cmd   = push(cmd, mk_slot(CH_COMP, b, b == 8'd0));
					acc_d = '0;
					if (b < LEN_EXT_BASE) begin
						pay_left_d = {25'd0, b};
						phase_d    = (b == 8'd0) ? PH_IDLE : PH_PAY;
					end else begin
						case (b)
							LEN_EXT2: lenb_left_d = 3'd2;
							LEN_EXT3: lenb_left_d = 3'd3;
							LEN_EXT4: lenb_left_d = 3'd4;
							default:  lenb_left_d = 3'd1;
						endcase
						phase_d = PH_LENB;
					end
				end
			end
			PH_LENB: begin
				acc_d = {acc_q[23:0], b};
				cmd   = push(cmd, mk_slot(CH_COMP, b, 1'b0));
				lb    = lenb_left_q - {2'd0, (lenb_left_q != 3'd0)};
				lenb_left_d = lb;
				if (lb == 3'd0) begin
					pay_left_d = {1'b0, acc_d} + 33'd1;
					phase_d    = PH_PAY;
				end
			end
			PH_PAY: begin
				pl = pay_left_q - {32'd0, (pay_left_q != 33'd0)};
				pay_left_d = pl;
				cmd = push(cmd, mk_slot(CH_COMP, b, pl == 33'd0));
				if (pl == 33'd0) begin
					phase_d = PH_IDLE;
				end
			end
			PH_NL: begin
				if (b == NL_TAIL) begin
					cmd = push(cmd, mk_slot(CH_TEXT, CARRIAGE_RETURN, 1'b0));
				end else begin
					cmd = push(cmd, mk_slot(CH_TEXT, sentinel_q, 1'b0));
					cmd = push(cmd, mk_slot(CH_COMP, sentinel_q, 1'b0));
					cmd = push(cmd, mk_slot(CH_COMP, held_type_q, 1'b0));
					cmd = push(cmd, mk_slot(CH_COMP, held_code_q, 1'b0));
					cmd = push(cmd, mk_slot(CH_COMP, b, 1'b1));
				end
				pay_left_d = '0;
				phase_d    = PH_IDLE;
			end
			default: begin
			end
		endcase

		// close the string: report an open segment, clear a latched error
		if (byte_data.string_end) begin
			if (phase_d == PH_ERR || err_q) begin
				phase_d = PH_IDLE;
				err_d   = 1'b0;
			end else if (phase_d != PH_IDLE) begin
				cmd     = push(cmd, mk_slot(CH_ERR, ERR_TRUNCATED, 1'b0));
				phase_d = PH_IDLE;
			end
			lenb_left_d = '0;
			pay_left_d  = '0;
		end
	end

	assign q_push = accept && (cmd.count != '0);
	assign q_cmd  = cmd;

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sentinel_q  <= SENTINEL_RESET;
			phase_q     <= PH_IDLE;
			held_type_q <= '0;
			held_code_q <= '0;
			acc_q       <= '0;
			lenb_left_q <= '0;
			pay_left_q  <= '0;
			err_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				sentinel_q <= cfg_data;
			end
			if (accept) begin
				phase_q     <= phase_d;
				held_type_q <= held_type_d;
				held_code_q <= held_code_d;
				acc_q       <= acc_d;
				lenb_left_q <= lenb_left_d;
				pay_left_q  <= pay_left_d;
				err_q       <= err_d;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/essc_queue.sv =====
// ---------------------------------------------------------------------------
// essc_queue
// Short command queue between the parser and the result sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module essc_queue import essc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_en,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop_en,
	output logic      head_valid,
	output cmd_t      head
);

	cmd_t             entries_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0] count_q;
	logic             do_push, do_pop;

	assign full       = (count_q == QCntW'(QueueDepth));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];
	assign do_push    = push_en && !full;
	assign do_pop     = pop_en && head_valid;

	// store commands
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`include "escaped_text_segment_splitter_unit_assert.svh"
	`ESSC_ASSERT_ALWAYS(a_count_bound, count_q <= QCntW'(QueueDepth), "queue overfilled")
	`ESSC_ASSERT_IMPLIES(a_push_on_full, push_en, !full, "command pushed into full queue")

endmodule
`default_nettype wire

// ===== design/essc_back.sv =====
// ---------------------------------------------------------------------------
// essc_back
// Result sequencer: walks the head command one result per cycle into the
// output register while the output is not stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module essc_back import essc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire cmd_t head,
	output logic      pop_en,
	output logic      result_valid,
	input  wire logic result_ready,
	output out_word_t result_data
);

	logic [CntW-1:0] slot_idx_q;
	logic            out_valid_q;
	out_word_t       out_q;
	logic            load;
	logic            final_slot;
	slot_t           cur;

	assign load       = head_valid && (!out_valid_q || result_ready);
	assign final_slot = (slot_idx_q == head.count - 1'b1);
	assign cur        = head.slots[slot_idx_q];
	assign pop_en     = load && final_slot;

	// drive the output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.channel       <= cur.channel;
			out_q.value         <= cur.value;
			out_q.component_end <= cur.component_end;
			out_q.last          <= final_slot;
		end
	end

	// step through the command, hold the word while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				slot_idx_q  <= final_slot ? '0 : slot_idx_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

`include "escaped_text_segment_splitter_unit_assert.svh"
	`ESSC_ASSERT_IMPLIES(a_idx_range, head_valid, slot_idx_q < head.count, "slot index past command")
	`ESSC_ASSERT_IMPLIES(a_idx_idle, !head_valid, slot_idx_q == '0, "slot index left mid command")

endmodule
`default_nettype wire

// ===== design/escaped_text_segment_splitter_unit.sv =====
// Escaped text segment splitter.
// byte channel (byte_valid/byte_ready/byte_data) takes one raw byte per
// cycle with its end-of-string flag. result channel (result_valid/
// result_ready/result_data) delivers text bytes, component bytes and error
// reports, with last set on the final result caused by each byte. The cfg
// channel writes the sentinel byte; it is always ready.
// A byte's first result is registered first in the command queue, then in
// the output register.
// Throughput: one byte per cycle while the four-entry command queue has
// room; the back end sends one result per cycle unless the receiver stalls,
// and a byte causes from 0 to 5 results. byte_ready is low only while the
// queue is full.
// A stalled receiver holds the output register; the queue keeps filling
// until full, then byte_ready drops. Reset returns the parser to outside
// any segment, clears the queue and sets the sentinel to 0x02.
// ---------------------------------------------------------------------------
// escaped_text_segment_splitter_unit
// Top level: parser, command queue and result sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module escaped_text_segment_splitter_unit import essc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_ready,
	input  wire in_word_t   byte_data,
	output logic            result_valid,
	input  wire logic       result_ready,
	output out_word_t       result_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data
);

	logic q_full, q_push, q_pop, q_head_valid;
	cmd_t q_cmd, q_head;

	// classify bytes
	essc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	// buffer commands
	essc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_en    (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop_en     (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// emit results
	essc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_head_valid),
		.head         (q_head),
		.pop_en       (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

endmodule
`default_nettype wire

// ===== tb/escaped_text_segment_splitter_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Escaped text segment splitter testbench
// Feeds byte strings of plain text, newline segments, component segments,
// unknown length codes and cut-off segments. A scoreboard class tracks the
// splitter state, works out the text/component/error words that each
// accepted byte should produce, and checks the result channel in order.
// Both channels idle in random bursts. The sentinel is rewritten between
// phases once the result channel has drained.
// ---------------------------------------------------------------------------
module escaped_text_segment_splitter_unit_tb;
	import essc_pkg::*;

	localparam int CycleLimit  = 200000;
	localparam int DrainCycles = 24;

	localparam logic [7:0] LEN_ZERO    = 8'h00;
	localparam logic [7:0] LEN_UNKNOWN = 8'hF7;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_OPENED,
		PH_TYPE_HELD,
		PH_TYPE,
		PH_LEN_BYTES,
		PH_PAYLOAD,
		PH_NL_CODE,
		PH_ERR
	} seg_phase_e;

	// Track splitter state and the words each byte should produce
	class segment_scoreboard;
		logic [7:0]  sentinel;
		seg_phase_e  seg_phase;
		logic [7:0]  held_type;
		logic [7:0]  held_code;
		logic [31:0] len_acc;
		logic [2:0]  len_left;
		logic [32:0] pay_left;
		bit          err_latched;
		out_word_t   step_words[$];
		out_word_t   expected_words[$];
		int          mismatches;

		function new();
			sentinel    = SENTINEL_RESET;
			seg_phase   = PH_IDLE;
			held_type   = '0;
			held_code   = '0;
			len_acc     = '0;
			len_left    = '0;
			pay_left    = '0;
			err_latched = 1'b0;
			mismatches  = 0;
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 100) begin
				$display("MISMATCH %0d at %0t: %s", mismatches, $realtime, msg);
			end
		endfunction

		function void emit(logic [1:0] ch, logic [7:0] val, logic fin);
			out_word_t w;
			if (step_words.size() >= MaxRes) begin
				return;
			end
			w.channel       = ch;
			w.value         = val;
			w.component_end = fin;
			w.last          = 1'b0;
			step_words      = {step_words, w};
		endfunction

		// marker on the text side, then opener and type as component words
		function void release_head();
			emit(CH_TEXT, sentinel, 1'b0);
			emit(CH_COMP, sentinel, 1'b0);
			emit(CH_COMP, held_type, 1'b0);
		endfunction

		function bit known_code(logic [7:0] c);
			return c < LEN_EXT_BASE || c == LEN_EXT1A || c == LEN_EXT1B ||
				c == LEN_EXT2 || c == LEN_EXT3 || c == LEN_EXT4;
		endfunction

		function void take_code(logic [7:0] c, bit held);
			held_code = c;
			// still on track for a newline: keep holding
			if (held && c == NL_CODE) begin
				seg_phase = PH_NL_CODE;
				return;
			end
			if (!known_code(c)) begin
				emit(CH_ERR, ERR_UNKNOWN, 1'b0);
				seg_phase   = PH_ERR;
				err_latched = 1'b1;
				return;
			end
			if (held) begin
				release_head();
			end
			emit(CH_COMP, c, c == LEN_ZERO);
			len_acc = '0;
			if (c < LEN_EXT_BASE) begin
				pay_left  = {25'd0, c};
				seg_phase = (c == LEN_ZERO) ? PH_IDLE : PH_PAYLOAD;
				return;
			end
			case (c)
				LEN_EXT2: len_left = 3'd2;
				LEN_EXT3: len_left = 3'd3;
				LEN_EXT4: len_left = 3'd4;
				default:  len_left = 3'd1;
			endcase
			seg_phase = PH_LEN_BYTES;
		endfunction

		// Predict the words for one accepted byte and queue them
		function void note_byte(in_word_t w);
			logic [7:0] b;
			bit         err_before;
			out_word_t  tail;
			b          = w.data_byte;
			err_before = err_latched;
			step_words.delete();
			case (seg_phase)
				PH_IDLE: begin
					if (b == sentinel) begin
						seg_phase = PH_OPENED;
					end else begin
						emit(CH_TEXT, b, 1'b0);
					end
				end
				PH_OPENED: begin
					held_type = b;
					if (sentinel == NL_OPENER && b == NL_TYPE) begin
						seg_phase = PH_TYPE_HELD;
					end else begin
						release_head();
						seg_phase = PH_TYPE;
					end
				end
				PH_TYPE_HELD: take_code(b, 1'b1);
				PH_TYPE: take_code(b, 1'b0);
				PH_LEN_BYTES: begin
					len_acc = {len_acc[23:0], b};
					emit(CH_COMP, b, 1'b0);
					if (len_left != 0) begin
						len_left = len_left - 3'd1;
					end
					if (len_left == 0) begin
						pay_left  = {1'b0, len_acc} + 33'd1;
						seg_phase = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (pay_left != 0) begin
						pay_left = pay_left - 33'd1;
					end
					emit(CH_COMP, b, pay_left == 0);
					if (pay_left == 0) begin
						seg_phase = PH_IDLE;
					end
				end
				PH_NL_CODE: begin
					if (b == NL_TAIL) begin
						emit(CH_TEXT, CARRIAGE_RETURN, 1'b0);
					end else begin
						release_head();
						emit(CH_COMP, held_code, 1'b0);
						emit(CH_COMP, b, 1'b1);
					end
					pay_left  = '0;
					seg_phase = PH_IDLE;
				end
				default: ;
			endcase

			// end of string: drop the error quietly or flag a cut-off segment
			if (w.string_end) begin
				if (seg_phase == PH_ERR || err_before) begin
					seg_phase   = PH_IDLE;
					err_latched = 1'b0;
				end else if (seg_phase != PH_IDLE) begin
					emit(CH_ERR, ERR_TRUNCATED, 1'b0);
					seg_phase = PH_IDLE;
				end
				len_left = '0;
				pay_left = '0;
			end

			if (step_words.size() != 0) begin
				tail      = step_words[step_words.size() - 1];
				tail.last = 1'b1;
				step_words[step_words.size() - 1] = tail;
			end
			expected_words = {expected_words, step_words};
		endfunction

		function void check_result(out_word_t r);
			out_word_t e;
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected word ch=%0d value=%02h end=%0b last=%0b",
					r.channel, r.value, r.component_end, r.last));
				return;
			end
			e = expected_words.pop_front();
			if (r.channel !== e.channel || r.value !== e.value ||
					r.component_end !== e.component_end || r.last !== e.last) begin
				report($sformatf("got ch=%0d value=%02h end=%0b last=%0b, want %0d %02h %0b %0b",
					r.channel, r.value, r.component_end, r.last,
					e.channel, e.value, e.component_end, e.last));
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_ready;
	in_word_t   byte_data = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	out_word_t  result_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = '0;

	logic       idle_on = 1'b1;
	int         stall_left = 0;
	int         cycle_count = 0;
	int         bytes_sent = 0;
	logic [7:0] sq[$];

	segment_scoreboard sb;

	escaped_text_segment_splitter_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// Check each accepted word, stall the receiver in bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				sb.check_result(result_data);
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				result_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 5);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Hold the byte word until it is taken, with an optional gap first
	task automatic send_byte(logic [7:0] b, logic e);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data.data_byte <= b;
		byte_data.string_end <= e;
		do @(posedge clk); while (!byte_ready);
		sb.note_byte('{data_byte: b, string_end: e});
		bytes_sent++;
	endtask

	task automatic send_string();
		foreach (sq[i]) begin
			send_byte(sq[i], i == sq.size() - 1);
		end
	endtask

	// Wait until nothing is expected and the block has gone quiet
	task automatic drain();
		byte_valid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_sentinel(logic [7:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.sentinel = v;
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] x;
		do x = 8'($urandom_range(0, 255)); while (x == sb.sentinel);
		return x;
	endfunction

	// Append one byte to the string under construction
	function automatic void sq_add(logic [7:0] x);
		sq = {sq, x};
	endfunction

	function automatic void add_payload(int n);
		repeat (n) sq_add(8'($urandom_range(0, 255)));
	endfunction

	// One complete segment with a random length form
	function automatic void add_segment();
		logic [7:0] t;
		int         form;
		int         v;
		t = ($urandom_range(0, 3) == 0) ? NL_TYPE : 8'($urandom_range(0, 255));
		sq_add(sb.sentinel);
		sq_add(t);
		form = $urandom_range(0, 9);
		v    = $urandom_range(0, 4);
		case (form)
			0: sq_add(LEN_ZERO);
			5: begin
				sq_add($urandom_range(0, 1) ? LEN_EXT1A : LEN_EXT1B);
				sq_add(8'(v));
				add_payload(v + 1);
			end
			6: begin
				sq_add(LEN_EXT2);
				sq_add(8'h00);
				sq_add(8'(v));
				add_payload(v + 1);
			end
			7: begin
				sq_add(LEN_EXT3);
				repeat (2) sq_add(8'h00);
				sq_add(8'(v));
				add_payload(v + 1);
			end
			8: begin
				sq_add(LEN_EXT4);
				repeat (3) sq_add(8'h00);
				sq_add(8'(v));
				add_payload(v + 1);
			end
			9: begin
				v = $urandom_range(7, 40);
				sq_add(8'(v));
				add_payload(v);
			end
			default: begin
				v = $urandom_range(1, 6);
				sq_add(8'(v));
				add_payload(v);
			end
		endcase
	endfunction

	// Mostly well-formed strings; some end in an error or a cut-off segment
	function automatic void build_string();
		int         pieces;
		int         k;
		int         start;
		bit         done;
		logic [7:0] c;
		sq.delete();
		pieces = $urandom_range(1, 4);
		done   = 1'b0;
		while (pieces > 0 && !done) begin
			pieces--;
			k = $urandom_range(0, 19);
			if (k < 9 && k >= 5) begin
				add_segment();
			end else if (k < 11 && k >= 9) begin
				sq_add(sb.sentinel);
				sq_add(NL_TYPE);
				sq_add(NL_CODE);
				sq_add(NL_TAIL);
			end else if (k == 11) begin
				sq_add(sb.sentinel);
				sq_add(NL_TYPE);
				sq_add(NL_CODE);
				do c = 8'($urandom_range(0, 255)); while (c == NL_TAIL);
				sq_add(c);
			end else if (k == 12) begin
				sq_add(sb.sentinel);
				sq_add(8'($urandom_range(0, 255)));
				do c = 8'($urandom_range(8'hF3, 8'hFF));
				while (c == LEN_EXT3 || c == LEN_EXT4);
				sq_add(c);
				add_payload($urandom_range(0, 3));
				done = 1'b1;
			end else if (k == 13 || k == 14) begin
				start = sq.size();
				add_segment();
				repeat ($urandom_range(1, sq.size() - start - 1)) void'(sq.pop_back());
				done = 1'b1;
			end else if (k == 15) begin
				// huge length, string ends long before the payload does
				sq_add(sb.sentinel);
				sq_add(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1)) begin
					sq_add(LEN_EXT4);
					sq_add(8'($urandom_range(1, 255)));
					add_payload(3);
				end else begin
					sq_add(LEN_EXT2);
					sq_add(8'($urandom_range(16, 255)));
					add_payload(1);
				end
				add_payload($urandom_range(0, 3));
				done = 1'b1;
			end else begin
				repeat ($urandom_range(1, 4)) sq_add(text_byte());
			end
		end
	endfunction

	task automatic random_phase(int target);
		int start;
		int n;
		start = bytes_sent;
		while (bytes_sent - start < target) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise with scattered string ends
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					send_byte(8'($urandom_range(0, 255)),
						i == n - 1 || $urandom_range(0, 3) == 0);
				end
			end else begin
				build_string();
				send_string();
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings at the reset sentinel
		sq = {8'h00, 8'hFF, 8'h41};
		send_string();
		sq = {SENTINEL_RESET, NL_TYPE, NL_CODE, NL_TAIL};
		send_string();
		sq = {SENTINEL_RESET, 8'h20, LEN_ZERO};
		send_string();
		sq = {SENTINEL_RESET, NL_TYPE, NL_CODE, 8'h07};
		send_string();
		sq = {SENTINEL_RESET, 8'h30, LEN_EXT1B, 8'h00, 8'hAA};
		send_string();
		sq = {SENTINEL_RESET, 8'h30, LEN_UNKNOWN, 8'h55};
		send_string();
		sq = {SENTINEL_RESET, 8'h30, 8'h03, 8'h11};
		send_string();

		random_phase(100);
		write_sentinel(8'h00);
		random_phase(60);
		write_sentinel(8'hFF);
		random_phase(60);
		write_sentinel(8'($urandom_range(0, 255)));
		random_phase(50);
		write_sentinel(SENTINEL_RESET);
		idle_on <= 1'b0;
		random_phase(60);
		drain();

		if (sb.mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
